// ===== sv/essc_pkg.sv =====
// Package with the request, response and register types of the encoder speed step controller.
`timescale 1ns / 1ps
`default_nettype none
package essc_pkg;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [15:0] wheel_count;
   } req_type;

   typedef struct packed {
      logic signed [31:0] speed;
      logic [6:0]         duty;
      logic               duty_changed;
   } rsp_type;

   localparam logic [1:0] CSR_TARGET_SPEED       = 2'd0;
   localparam logic [1:0] CSR_DISTANCE_PER_COUNT = 2'd1;
   localparam logic [1:0] CSR_SAMPLE_PERIOD_MS   = 2'd2;
   localparam logic [1:0] CSR_FEEDBACK_ENABLE    = 2'd3;

   localparam logic [23:0] TARGET_SPEED_RESET       = 24'd51405;
   localparam logic [15:0] DISTANCE_PER_COUNT_RESET = 16'd4096;
   localparam logic [15:0] SAMPLE_PERIOD_RESET      = 16'd500;

   localparam logic [6:0] DUTY_RESET = 7'd40;
   localparam logic [6:0] DUTY_MAX   = 7'd100;
   localparam logic [9:0] MS_PER_S   = 10'd1000;

endpackage
`default_nettype wire

// ===== sv/encoder_speed_step_controller.sv =====
// Encoder speed measurement with a step duty controller, using one serial divider.
`timescale 1ns / 1ps
`default_nettype none
//
//  Channel   Direction  Handshake              Payload
//  req       in         req_valid / req_stall  req_type (now_ms, wheel_count)
//  rsp       out        rsp_valid / rsp_stall  rsp_type (speed, duty, duty_changed)
//  csr       in         csr_we                 csr_index, csr_wdata
//
//  A request that does not reach the sample period gives no response.
//  A sample passes through accept, check, two multiply steps, 42 divider steps,
//  saturation, and the output load, in that order; the divider is a 42-step restoring divider.
//  Reset is synchronous and active high; it restores register defaults and duty 40.
//  A stalled response holds the block in its last step until the output register frees.
//
module encoder_speed_step_controller
   import essc_pkg::*;
#(
   parameter int RUN_LENGTH = 3
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire req_type     req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      rsp_type     rsp_data,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_SCALE = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_SAT   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   localparam int          NUM_W    = 42;
   localparam logic [5:0]  DIV_LAST = 6'(NUM_W - 1);
   localparam logic [1:0]  RUN_LAST = 2'(RUN_LENGTH);

   logic [2:0]         state_ff, state_in;
   logic [31:0]        now_ff, now_in;
   logic [15:0]        count_ff, count_in;
   logic [31:0]        elapsed_ff, elapsed_in;
   logic               neg_ff, neg_in;
   logic [15:0]        mag_ff, mag_in;
   logic [31:0]        prod_ff, prod_in;
   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [31:0]        rem_ff, rem_in;
   logic [5:0]         bit_cnt_ff, bit_cnt_in;
   logic [31:0]        speed_ff, speed_in;

   logic [23:0]        target_ff, target_in;
   logic [15:0]        dpc_ff, dpc_in;
   logic [15:0]        period_ff, period_in;
   logic               fb_en_ff, fb_en_in;

   logic [31:0]        last_stamp_ff, last_stamp_in;
   logic [15:0]        last_count_ff, last_count_in;
   logic [1:0]         above_run_ff, above_run_in;
   logic [1:0]         below_run_ff, below_run_in;
   logic [6:0]         duty_ff, duty_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [15:0]        period_eff;
   logic [16:0]        delta;
   logic [32:0]        shifted;
   logic [33:0]        trial;
   logic               is_above;
   logic               is_below;
   logic [1:0]         above_next;
   logic [1:0]         below_next;
   logic               changed;

   assign period_eff = (period_ff == 16'd0) ? 16'd1 : period_ff;
   assign delta      = {1'b0, count_ff} - {1'b0, last_count_ff};
   assign shifted    = {rem_ff, quo_ff[NUM_W-1]};
   assign trial      = {1'b0, shifted} - {2'b00, elapsed_ff};
   assign is_above   = $signed(speed_ff) > $signed({8'd0, target_ff});
   assign is_below   = $signed(speed_ff) < $signed({8'd0, target_ff});
   assign above_next = above_run_ff + 2'd1;
   assign below_next = below_run_ff + 2'd1;

   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      count_in      = count_ff;
      elapsed_in    = elapsed_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      prod_in       = prod_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      bit_cnt_in    = bit_cnt_ff;
      speed_in      = speed_ff;
      last_stamp_in = last_stamp_ff;
      last_count_in = last_count_ff;
      above_run_in  = above_run_ff;
      below_run_in  = below_run_ff;
      duty_in       = duty_ff;
      changed       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               now_in     = req_data.now_ms;
               count_in   = req_data.wheel_count;
               elapsed_in = req_data.now_ms - last_stamp_ff;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (elapsed_ff < {16'd0, period_eff}) begin
               state_in = S_IDLE;
            end else begin
               neg_in        = delta[16];
               mag_in        = delta[16] ? 16'(-delta) : delta[15:0];
               last_stamp_in = now_ff;
               last_count_in = count_ff;
               state_in      = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = {16'd0, mag_ff} * {16'd0, dpc_ff};
            state_in = S_SCALE;
         end
         S_SCALE: begin
            quo_in     = {10'd0, prod_ff} * {32'd0, MS_PER_S};
            rem_in     = 32'd0;
            bit_cnt_in = 6'd0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            if (!trial[33]) begin
               rem_in = trial[31:0];
            end else begin
               rem_in = shifted[31:0];
            end
            quo_in     = {quo_ff[NUM_W-2:0], ~trial[33]};
            bit_cnt_in = bit_cnt_ff + 6'd1;
            if (bit_cnt_ff == DIV_LAST) begin
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            if (neg_ff) begin
               if (quo_ff > {10'd0, 32'h8000_0000}) begin
                  speed_in = 32'h8000_0000;
               end else begin
                  speed_in = 32'(-quo_ff[31:0]);
               end
            end else begin
               if (quo_ff > {10'd0, 32'h7FFF_FFFF}) begin
                  speed_in = 32'h7FFF_FFFF;
               end else begin
                  speed_in = quo_ff[31:0];
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               if (fb_en_ff) begin
                  if (is_above) begin
                     below_run_in = 2'd0;
                     above_run_in = above_next;
                     if (above_next == RUN_LAST) begin
                        if (duty_ff != 7'd0) begin
                           duty_in = duty_ff - 7'd1;
                           changed = 1'b1;
                        end
                        above_run_in = 2'd0;
                     end
                  end else if (is_below) begin
                     above_run_in = 2'd0;
                     below_run_in = below_next;
                     if (below_next == RUN_LAST) begin
                        if (duty_ff < DUTY_MAX) begin
                           duty_in = duty_ff + 7'd1;
                           changed = 1'b1;
                        end
                        below_run_in = 2'd0;
                     end
                  end
               end
               rsp_valid_in             = 1'b1;
               rsp_data_in.speed        = $signed(speed_ff);
               rsp_data_in.duty         = duty_in;
               rsp_data_in.duty_changed = changed;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      target_in = target_ff;
      dpc_in    = dpc_ff;
      period_in = period_ff;
      fb_en_in  = fb_en_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TARGET_SPEED:       target_in = csr_wdata;
            CSR_DISTANCE_PER_COUNT: dpc_in    = csr_wdata[15:0];
            CSR_SAMPLE_PERIOD_MS:   period_in = csr_wdata[15:0];
            CSR_FEEDBACK_ENABLE:    fb_en_in  = csr_wdata[0];
            default: begin
               target_in = target_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         target_ff     <= TARGET_SPEED_RESET;
         dpc_ff        <= DISTANCE_PER_COUNT_RESET;
         period_ff     <= SAMPLE_PERIOD_RESET;
         fb_en_ff      <= 1'b1;
         last_stamp_ff <= 32'd0;
         last_count_ff <= 16'd0;
         above_run_ff  <= 2'd0;
         below_run_ff  <= 2'd0;
         duty_ff       <= DUTY_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         target_ff     <= target_in;
         dpc_ff        <= dpc_in;
         period_ff     <= period_in;
         fb_en_ff      <= fb_en_in;
         last_stamp_ff <= last_stamp_in;
         last_count_ff <= last_count_in;
         above_run_ff  <= above_run_in;
         below_run_ff  <= below_run_in;
         duty_ff       <= duty_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      count_ff    <= count_in;
      elapsed_ff  <= elapsed_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      bit_cnt_ff  <= bit_cnt_in;
      speed_ff    <= speed_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      duty_ff <= DUTY_MAX)
      else $error("duty level above its maximum");

   a_runs_exclusive: assert property (@(posedge clock) disable iff (reset)
      (above_run_ff == 2'd0) || (below_run_ff == 2'd0))
      else $error("above and below runs both active");

   a_duty_step_reported: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (duty_ff != $past(duty_ff))) |->
         (rsp_valid_ff && rsp_data_ff.duty_changed && (rsp_data_ff.duty == duty_ff)))
      else $error("duty changed without a matching response");

endmodule
`default_nettype wire
